/* rtl/core/ntms_pkg.sv */
// ----------------------------------------------------------------------------
// ntms_pkg: shared types and constants for the note table merge sort
// Operation and status codes, table geometry, entry layout and sort order.
// ----------------------------------------------------------------------------
package ntms_pkg;

  localparam int Capacity = 256;
  localparam int AddrW = $clog2(Capacity);
  localparam int CountW = AddrW + 1;
  localparam int EntryW = 8 + 8 + 32 + 8 + 31;

  typedef enum logic [2:0] {
    FUNC_ADD    = 3'd0,
    FUNC_MERGE  = 3'd1,
    FUNC_FINISH = 3'd2,
    FUNC_READ   = 3'd3,
    FUNC_CLEAR  = 3'd4
  } func_t;

  typedef enum logic [2:0] {
    ST_STORED  = 3'd0,
    ST_DUP     = 3'd1,
    ST_FULL    = 3'd2,
    ST_DONE    = 3'd3,
    ST_BAD_IDX = 3'd4
  } status_t;

  typedef struct packed {
    logic [7:0]         channel;
    logic [7:0]         pitch;
    logic signed [31:0] start;
    logic [7:0]         velocity;
    logic [30:0]        duration;
  } note_t;

  function automatic logic sorts_before(note_t a, note_t b);
    logic r;
    if (a.start != b.start) r = a.start < b.start;
    else if (a.pitch != b.pitch) r = a.pitch < b.pitch;
    else r = a.channel < b.channel;
    return r;
  endfunction

endpackage

/* rtl/core/note_table_merge_sort.sv */
// ----------------------------------------------------------------------------
// note_table_merge_sort: bounded note table with dedupe merge and sort
// Merge scans every held entry for a duplicate before storing; finish sorts
// the table in place by insertion sort, one memory read a step.
// One word at a time; the next word waits for idle and a taken result.
// Reset: counters and lengths clear at once; the table needs no clearing pass.
// ----------------------------------------------------------------------------
module note_table_merge_sort (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         func,
  input  logic [7:0]         channel,
  input  logic [7:0]         pitch,
  input  logic signed [31:0] start_tick,
  input  logic [7:0]         velocity,
  input  logic [30:0]        duration,
  input  logic [7:0]         index,
  input  logic signed [31:0] other_length,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [2:0]         status,
  output logic [8:0]         refused_count,
  output logic [8:0]         entry_count,
  output logic [7:0]         out_channel,
  output logic [7:0]         out_pitch,
  output logic signed [31:0] out_start,
  output logic [7:0]         out_velocity,
  output logic [30:0]        out_duration,
  output logic signed [31:0] list_length
);

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_SCAN   = 8'b0000_0010,
    S_CHECK  = 8'b0000_0100,
    S_SORT_I = 8'b0000_1000,
    S_SORT_J = 8'b0001_0000,
    S_SORT_C = 8'b0010_0000,
    S_READ   = 8'b0100_0000,
    S_OUT    = 8'b1000_0000
  } state_t;

  state_t state;
  ntms_pkg::note_t mem [ntms_pkg::Capacity];
  ntms_pkg::note_t rdata, cur, note;
  logic [ntms_pkg::AddrW-1:0] raddr;
  logic rd_en;
  logic                     wr_en;
  logic [ntms_pkg::AddrW-1:0] waddr;
  ntms_pkg::note_t          wdata;

  logic [2:0] op;
  logic [ntms_pkg::CountW-1:0] held, ptr, pos;
  logic [ntms_pkg::CountW-1:0] i_idx;
  logic [8:0] refusals;
  logic signed [31:0] stored_length;
  logic dup;

  always_ff @(posedge clk) begin
    if (wr_en) mem[waddr] <= wdata;
    if (rd_en) rdata <= mem[raddr];
  end

  assign in_stall = (state != S_IDLE) || (out_valid && out_stall);

  always_comb begin
    rd_en = 1'b0;
    raddr = '0;
    wr_en = 1'b0;
    waddr = '0;
    wdata = cur;
    unique case (state)
      S_SCAN: begin
        rd_en = 1'b1;
        raddr = ptr[ntms_pkg::AddrW-1:0];
      end
      S_SORT_I: begin
        rd_en = 1'b1;
        raddr = i_idx[ntms_pkg::AddrW-1:0];
      end
      S_SORT_J: begin
        rd_en = (pos != '0);
        raddr = pos[ntms_pkg::AddrW-1:0] - 1'b1;
      end
      S_SORT_C: begin
        wr_en = 1'b1;
        waddr = pos[ntms_pkg::AddrW-1:0];
        if (pos != '0 && ntms_pkg::sorts_before(cur, rdata)) wdata = rdata;
      end
      S_READ: begin
        rd_en = 1'b1;
        raddr = ptr[ntms_pkg::AddrW-1:0];
      end
      S_CHECK: begin
        wr_en = !dup && (held < ntms_pkg::CountW'(ntms_pkg::Capacity));
        waddr = held[ntms_pkg::AddrW-1:0];
        wdata = note;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      held <= '0;
      refusals <= '0;
      stored_length <= '0;
    end else begin
      if (out_valid && !out_stall) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: if (in_valid && !in_stall) begin
          op <= func;
          note <= '{channel, pitch, start_tick, velocity, duration};
          ptr <= '0;
          dup <= 1'b0;
          refused_count <= '0;
          out_channel <= '0;
          out_pitch <= '0;
          out_start <= '0;
          out_velocity <= '0;
          out_duration <= '0;
          status <= ntms_pkg::ST_DONE;
          case (func)
            ntms_pkg::FUNC_ADD: begin
              if (held < ntms_pkg::CountW'(ntms_pkg::Capacity)) begin
                status <= ntms_pkg::ST_STORED;
              end else begin
                status <= ntms_pkg::ST_FULL;
              end
              dup <= 1'b0;
              state <= S_CHECK;
            end
            ntms_pkg::FUNC_MERGE: state <= (held == '0) ? S_CHECK : S_SCAN;
            ntms_pkg::FUNC_FINISH: begin
              if (other_length > stored_length) stored_length <= other_length;
              refused_count <= refusals;
              refusals <= '0;
              i_idx <= ntms_pkg::CountW'(1);
              state <= (held > ntms_pkg::CountW'(1)) ? S_SORT_I : S_OUT;
            end
            ntms_pkg::FUNC_READ: begin
              ptr <= ntms_pkg::CountW'(index);
              if (ntms_pkg::CountW'(index) < held) begin
                state <= S_READ;
              end else begin
                status <= ntms_pkg::ST_BAD_IDX;
                state <= S_OUT;
              end
            end
            ntms_pkg::FUNC_CLEAR: begin
              held <= '0;
              stored_length <= '0;
              refusals <= '0;
              state <= S_OUT;
            end
            default: state <= S_OUT;
          endcase
        end
        S_SCAN: begin
          // compare previous read while issuing the next
          if (ptr != '0 && rdata.channel == note.channel && rdata.pitch == note.pitch &&
              rdata.start == note.start) dup <= 1'b1;
          if (ptr == held) begin
            state <= S_CHECK;
          end else begin
            ptr <= ptr + 1'b1;
          end
        end
        S_CHECK: begin
          if (op == ntms_pkg::FUNC_MERGE && dup) begin
            status <= ntms_pkg::ST_DUP;
          end else if (held < ntms_pkg::CountW'(ntms_pkg::Capacity)) begin
            status <= ntms_pkg::ST_STORED;
            held <= held + 1'b1;
          end else begin
            status <= ntms_pkg::ST_FULL;
            if (op == ntms_pkg::FUNC_MERGE && refusals != 9'h1FF) refusals <= refusals + 1'b1;
          end
          state <= S_OUT;
        end
        S_SORT_I: begin
          pos <= i_idx;
          state <= S_SORT_J;
        end
        S_SORT_J: begin
          if (pos == i_idx) cur <= rdata;
          if (pos == '0) begin
            state <= S_SORT_C;
          end else begin
            state <= S_SORT_C;
          end
        end
        S_SORT_C: begin
          if (pos != '0 && ntms_pkg::sorts_before(cur, rdata)) begin
            pos <= pos - 1'b1;
            state <= S_SORT_J;
          end else if (i_idx + 1'b1 == held) begin
            state <= S_OUT;
          end else begin
            i_idx <= i_idx + 1'b1;
            state <= S_SORT_I;
          end
        end
        S_READ: state <= S_OUT;
        S_OUT: begin
          if (op == ntms_pkg::FUNC_READ && status == ntms_pkg::ST_DONE) begin
            out_channel <= rdata.channel;
            out_pitch <= rdata.pitch;
            out_start <= rdata.start;
            out_velocity <= rdata.velocity;
            out_duration <= rdata.duration;
          end
          if (!out_valid || !out_stall) begin
            out_valid <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign entry_count = 9'(held);
  assign list_length = stored_length;

endmodule

/* bench/note_table_merge_sort_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// note_table_merge_sort_tb: self-checking bench for the note table merge sort
// A directed table of words covers empty, extreme and error cases. Two
// sessions then fill the table to capacity and merge into it while full.
// Random sessions follow: clear, fill, merge, finish and read back.
// An in-bench model of the table predicts the result words; some directed
// rows carry fixed ones. Both handshakes see random gaps and stalls.
// ----------------------------------------------------------------------------
module note_table_merge_sort_tb;

  typedef struct packed {
    logic [2:0]         status;
    logic [8:0]         refused;
    logic [8:0]         count;
    ntms_pkg::note_t    rd;
    logic signed [31:0] len;
  } reply_t;

  typedef struct {
    logic [2:0]         op;
    ntms_pkg::note_t    nt;
    logic [7:0]         idx;
    logic signed [31:0] other;
    bit                 typed;
    ntms_pkg::status_t  t_status;
    logic [8:0]         t_count;
    logic signed [31:0] t_len;
  } row_t;

  logic               clk = 0;
  logic               rst;
  logic               in_valid;
  logic               in_stall;
  logic [2:0]         func;
  logic [7:0]         channel;
  logic [7:0]         pitch;
  logic signed [31:0] start_tick;
  logic [7:0]         velocity;
  logic [30:0]        duration;
  logic [7:0]         index;
  logic signed [31:0] other_length;
  logic               out_valid;
  logic               out_stall;
  logic [2:0]         status;
  logic [8:0]         refused_count;
  logic [8:0]         entry_count;
  logic [7:0]         out_channel;
  logic [7:0]         out_pitch;
  logic signed [31:0] out_start;
  logic [7:0]         out_velocity;
  logic [30:0]        out_duration;
  logic signed [31:0] list_length;

  ntms_pkg::note_t    tbl [ntms_pkg::Capacity];
  int unsigned        held;
  logic signed [31:0] stored_len;
  int unsigned        refusals;

  reply_t replies_due [$];
  int     words_sent;
  int     replies_seen;
  int     mismatches;
  int     stall_left;
  int     fulls;

  note_table_merge_sort uut (.*);

  always #4 clk = ~clk;

  function automatic bit earlier(ntms_pkg::note_t a, ntms_pkg::note_t b);
    if (a.start != b.start) return $signed(a.start) < $signed(b.start);
    if (a.pitch != b.pitch) return a.pitch < b.pitch;
    return a.channel < b.channel;
  endfunction

  function automatic reply_t table_step(logic [2:0] op, ntms_pkg::note_t nt,
                                        logic [7:0] idx, logic signed [31:0] other);
    reply_t          r;
    ntms_pkg::note_t cur;
    bit              dup;
    int              j;
    r = '0;
    r.status = ntms_pkg::ST_DONE;
    case (op)
      ntms_pkg::FUNC_ADD: begin
        if (held < ntms_pkg::Capacity) begin
          tbl[held] = nt;
          held++;
          r.status = ntms_pkg::ST_STORED;
        end else r.status = ntms_pkg::ST_FULL;
      end
      ntms_pkg::FUNC_MERGE: begin
        dup = 0;
        for (int i = 0; i < held; i++)
          if (tbl[i].channel == nt.channel && tbl[i].pitch == nt.pitch &&
              tbl[i].start == nt.start) dup = 1;
        if (dup) r.status = ntms_pkg::ST_DUP;
        else if (held < ntms_pkg::Capacity) begin
          tbl[held] = nt;
          held++;
          r.status = ntms_pkg::ST_STORED;
        end else begin
          r.status = ntms_pkg::ST_FULL;
          if (refusals < 511) refusals++;
        end
      end
      ntms_pkg::FUNC_FINISH: begin
        if (other > stored_len) stored_len = other;
        for (int i = 1; i < held; i++) begin
          cur = tbl[i];
          j = i;
          while (j > 0 && earlier(cur, tbl[j-1])) begin
            tbl[j] = tbl[j-1];
            j--;
          end
          tbl[j] = cur;
        end
        r.refused = 9'(refusals);
        refusals = 0;
      end
      ntms_pkg::FUNC_READ: begin
        if (idx < held) r.rd = tbl[idx];
        else r.status = ntms_pkg::ST_BAD_IDX;
      end
      ntms_pkg::FUNC_CLEAR: begin
        held = 0;
        stored_len = 0;
        refusals = 0;
      end
      default: ;
    endcase
    r.count = 9'(held);
    r.len = stored_len;
    return r;
  endfunction

  function automatic int gap_len();
    int k;
    k = $urandom_range(0, 99);
    if (k < 50) return 0;
    if (k < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send(logic [2:0] op, ntms_pkg::note_t nt, logic [7:0] idx,
                      logic signed [31:0] other, bit typed, reply_t typed_reply);
    reply_t r;
    int g;
    func <= op;
    channel <= nt.channel;
    pitch <= nt.pitch;
    start_tick <= nt.start;
    velocity <= nt.velocity;
    duration <= nt.duration;
    index <= idx;
    other_length <= other;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    r = table_step(op, nt, idx, other);
    replies_due.push_back(typed ? typed_reply : r);
    words_sent++;
    g = gap_len();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  function automatic ntms_pkg::note_t rand_note(int pool);
    ntms_pkg::note_t n;
    n.channel = 8'(pool > 0 ? $urandom_range(0, pool) : $urandom_range(0, 255));
    n.pitch = 8'(pool > 0 ? $urandom_range(0, pool) : $urandom_range(0, 255));
    case ($urandom_range(0, 5))
      0: n.start = 32'sh7fffffff;
      1: n.start = 32'sh80000000;
      2, 3: n.start = $signed($urandom_range(0, 6)) - 3;
      default: n.start = $signed($urandom);
    endcase
    n.velocity = 8'($urandom_range(0, 255));
    n.duration = 31'($urandom);
    return n;
  endfunction

  task automatic send_rand(logic [2:0] op, ntms_pkg::note_t nt, logic [7:0] idx,
                           logic signed [31:0] other);
    send(op, nt, idx, other, 0, '0);
  endtask

  task automatic session(int notes, int pool);
    ntms_pkg::note_t nt;
    int reads;
    send_rand(ntms_pkg::FUNC_CLEAR, rand_note(0), 8'($urandom), $signed($urandom));
    for (int i = 0; i < notes; i++) begin
      nt = rand_note(pool);
      case ($urandom_range(0, 9))
        0, 1, 2: send_rand(ntms_pkg::FUNC_ADD, nt, 8'($urandom), $signed($urandom));
        3: send_rand(3'($urandom_range(3, 7)), nt, 8'($urandom_range(0, notes)),
                     $signed($urandom));
        default: send_rand(ntms_pkg::FUNC_MERGE, nt, 8'($urandom), $signed($urandom));
      endcase
    end
    if ($urandom_range(0, 9) != 0)
      send_rand(ntms_pkg::FUNC_FINISH, rand_note(0), 8'($urandom),
                $signed($urandom_range(0, 40)) - 10);
    else send_rand(ntms_pkg::FUNC_FINISH, rand_note(0), 8'($urandom), $signed($urandom));
    reads = notes < 10 ? notes + 2 : 10;
    for (int i = 0; i < reads; i++)
      send_rand(ntms_pkg::FUNC_READ, rand_note(0),
                8'($urandom_range(0, 7) == 0 ? $urandom : $urandom_range(0, notes)),
                $signed($urandom));
  endtask

  task automatic full_session(int extra_merges, int pool);
    ntms_pkg::note_t nt;
    send_rand(ntms_pkg::FUNC_CLEAR, rand_note(0), 8'($urandom), $signed($urandom));
    for (int i = 0; i < ntms_pkg::Capacity; i++)
      send_rand(ntms_pkg::FUNC_ADD, rand_note(pool), 8'($urandom), $signed($urandom));
    send_rand(ntms_pkg::FUNC_ADD, rand_note(0), 8'($urandom), $signed($urandom));
    for (int i = 0; i < extra_merges; i++) begin
      nt = $urandom_range(0, 3) == 0 ? tbl[$urandom_range(0, ntms_pkg::Capacity - 1)]
                                     : rand_note(0);
      send_rand(ntms_pkg::FUNC_MERGE, nt, 8'($urandom), $signed($urandom));
    end
    send_rand(ntms_pkg::FUNC_FINISH, rand_note(0), 8'($urandom), $signed($urandom));
    for (int i = 0; i < 12; i++)
      send_rand(ntms_pkg::FUNC_READ, rand_note(0), 8'($urandom), $signed($urandom));
    send_rand(ntms_pkg::FUNC_READ, rand_note(0), 8'hff, $signed($urandom));
  endtask

  // receiver stalls: short bursts, occasional long ones, quiet stretches
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left <= stall_left - 1;
    end else begin
      out_stall <= 1'b0;
      if ($urandom_range(0, 99) < 20)
        stall_left <= $urandom_range(0, 9) == 0 ? $urandom_range(10, 40) : $urandom_range(0, 2);
    end
  end

  always @(posedge clk) begin
    reply_t want;
    if (!rst && out_valid && !out_stall) begin
      replies_seen++;
      if (replies_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected word: status %0d", status);
      end else begin
        want = replies_due.pop_front();
        if (status !== want.status || refused_count !== want.refused ||
            entry_count !== want.count || out_channel !== want.rd.channel ||
            out_pitch !== want.rd.pitch || out_start !== want.rd.start ||
            out_velocity !== want.rd.velocity || out_duration !== want.rd.duration ||
            list_length !== want.len) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"word %0d: exp st %0d ref %0d cnt %0d nt %h len %0d",
                      " / got st %0d ref %0d cnt %0d nt %h len %0d"},
                     replies_seen, want.status, want.refused, want.count, want.rd, want.len,
                     status, refused_count, entry_count,
                     {out_channel, out_pitch, out_start, out_velocity, out_duration},
                     list_length);
        end
      end
    end
  end

  initial begin
    #40_000_000;
    $display("FAIL note_table_merge_sort");
    $finish;
  end

  initial begin
    row_t            rows [$];
    row_t            rw;
    reply_t          tr;
    ntms_pkg::note_t na, nb;
    held = 0;
    stored_len = 0;
    refusals = 0;
    words_sent = 0;
    replies_seen = 0;
    mismatches = 0;
    fulls = 0;
    rst <= 1'b1;
    in_valid <= 1'b0;
    func <= ntms_pkg::FUNC_CLEAR;
    channel <= '0;
    pitch <= '0;
    start_tick <= '0;
    velocity <= '0;
    duration <= '0;
    index <= '0;
    other_length <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    na = '{8'hff, 8'h00, 32'sh7fffffff, 8'hff, 31'h7fffffff};
    nb = '{8'h00, 8'hff, 32'sh80000000, 8'h00, 31'h0};
    rows.push_back('{ntms_pkg::FUNC_READ, na, 8'd0, 0, 1, ntms_pkg::ST_BAD_IDX, 9'd0, 0});
    rows.push_back('{ntms_pkg::FUNC_FINISH, na, 8'd0, -5, 1, ntms_pkg::ST_DONE, 9'd0, 0});
    rows.push_back('{ntms_pkg::FUNC_ADD, na, 8'd0, 0, 0, ntms_pkg::ST_DONE, 0, 0});
    rows.push_back('{ntms_pkg::FUNC_ADD, nb, 8'd0, 0, 0, ntms_pkg::ST_DONE, 0, 0});
    rows.push_back('{ntms_pkg::FUNC_MERGE, na, 8'd0, 0, 0, ntms_pkg::ST_DONE, 0, 0});
    rw = rows[2];
    rw.op = ntms_pkg::FUNC_MERGE;
    rw.nt.channel = 8'h00;
    rows.push_back(rw);
    rows.push_back('{ntms_pkg::FUNC_ADD, na, 8'd0, 0, 0, ntms_pkg::ST_DONE, 0, 0});
    rw.nt = '{8'h10, 8'h10, -1, 8'h5a, 31'h2aaaaaaa};
    rows.push_back(rw);
    rows.push_back('{ntms_pkg::FUNC_FINISH, na, 8'd0, 32'sh7fffffff, 0,
                     ntms_pkg::ST_DONE, 0, 0});
    for (int i = 0; i < 5; i++)
      rows.push_back('{ntms_pkg::FUNC_READ, na, i[7:0], 0, 0, ntms_pkg::ST_DONE, 0, 0});
    rows.push_back('{3'd5, na, 8'd0, 0, 0, ntms_pkg::ST_DONE, 0, 0});
    rows.push_back('{3'd6, nb, 8'd0, 0, 0, ntms_pkg::ST_DONE, 0, 0});
    rows.push_back('{3'd7, na, 8'hff, -1, 0, ntms_pkg::ST_DONE, 0, 0});
    rows.push_back('{ntms_pkg::FUNC_CLEAR, na, 8'd0, 0, 1, ntms_pkg::ST_DONE, 9'd0, 0});
    rows.push_back('{ntms_pkg::FUNC_READ, na, 8'd0, 0, 1, ntms_pkg::ST_BAD_IDX, 9'd0, 0});
    rows.push_back('{ntms_pkg::FUNC_READ, na, 8'hff, 0, 1, ntms_pkg::ST_BAD_IDX, 9'd0, 0});
    rows.push_back('{ntms_pkg::FUNC_FINISH, na, 8'd0, 32'sh80000000, 1,
                     ntms_pkg::ST_DONE, 9'd0, 0});
    rows.push_back('{ntms_pkg::FUNC_FINISH, na, 8'd0, 32'sh7fffffff, 1,
                     ntms_pkg::ST_DONE, 9'd0, 32'sh7fffffff});

    foreach (rows[i]) begin
      tr = '0;
      tr.status = rows[i].t_status;
      tr.count = rows[i].t_count;
      tr.len = rows[i].t_len;
      send(rows[i].op, rows[i].nt, rows[i].idx, rows[i].other, rows[i].typed, tr);
    end

    full_session(40, 0);
    full_session(530, 3);
    fulls = 2;
    while (words_sent < 1700) begin
      if ($urandom_range(0, 7) == 0) session($urandom_range(0, 30), 0);
      else session($urandom_range(1, 12), $urandom_range(0, 1) ? 2 : 0);
    end
    in_valid <= 1'b0;

    while (replies_due.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    $display("%0d words sent, %0d result words checked, %0d full-table sessions",
             words_sent, replies_seen, fulls);
    $display("%0d mismatches", mismatches);
    if (mismatches == 0) $display("PASS note_table_merge_sort");
    else $display("FAIL note_table_merge_sort");
    $finish;
  end

endmodule

/* note_table_merge_sort.f */
rtl/core/ntms_pkg.sv
rtl/core/note_table_merge_sort.sv
bench/note_table_merge_sort_tb.sv
